@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by ipv4_flow_packet_counter_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define AST_CHK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");

// Checked on every clock edge, reset included.
`define AST_CHK_ALL(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/fpc_pkg.sv @@
// ----------------------------------------------------------------------------
// fpc_pkg
// Types and constants for the IPv4 flow packet counter.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int TABLE_ENTRIES = 4096;
    localparam int WAYS          = 4;
    localparam int SETS          = TABLE_ENTRIES / WAYS;
    localparam int SET_W         = $clog2(SETS);
    localparam int WAY_W         = $clog2(WAYS);
    localparam int SLOT_W        = 12;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [6:0]  OFF_MAX        = 7'd127;

    localparam logic [2:0] ST_NOT_COUNTED = 3'd0;
    localparam logic [2:0] ST_HIT         = 3'd1;
    localparam logic [2:0] ST_NEW         = 3'd2;
    localparam logic [2:0] ST_NEW_EVICT   = 3'd3;
    localparam logic [2:0] ST_READ_VALID  = 3'd4;
    localparam logic [2:0] ST_READ_EMPTY  = 3'd5;

    localparam logic [1:0] K_NONE = 2'd0;
    localparam logic [1:0] K_DROP = 2'd1;
    localparam logic [1:0] K_FLOW = 2'd2;
    localparam logic [1:0] K_READ = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [11:0] entry_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [7:0]  ip_protocol;
        logic [15:0] destination_port;
        logic [63:0] packet_count;
        logic [11:0] slot;
    } t_out;

    typedef struct packed {
        logic [1:0]       kind;
        logic [63:0]      addrs;
        logic [23:0]      pp;
        logic [SET_W-1:0] row;
        logic [WAY_W-1:0] way;
    } t_req;

    typedef struct packed {
        logic             valid;
        logic [WAY_W-1:0] rec;
        logic [63:0]      addrs;
        logic [23:0]      pp;
        logic [63:0]      cnt;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    typedef struct packed {
        logic adv;
        logic busy;
    } t_ctl;

endpackage

@@ hw/rtl/ipv4_flow_packet_counter_unit.sv @@
// One transaction per cycle unless the input is stalled: frame bytes and table
// reads stream in back to back; each frame end or read gives its result through
// the request register, the set read from the single table RAM, and compare and
// write-back into the output register. A stalled result holds the input off.
// After reset a clearing pass writes every table set, one set per cycle, before
// the first transaction is taken.
// ----------------------------------------------------------------------------
// ipv4_flow_packet_counter_unit
// Counts IPv4 flows (IPs, proto, dst port) in a 4-way set-associative LRU table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipv4_flow_packet_counter_unit import fpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_ctl ctl;
    t_req req;
    logic accept;

    assign o_in_stall = ctl.busy || !ctl.adv;
    assign accept     = i_in_valid && !o_in_stall;

    fpc_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_adv    (ctl.adv),
        .i_in     (i_in_data),
        .o_req    (req)
    );

    fpc_table u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `AST_CHK_ALL(a_rst_starts_clear, !i_rst_n |=> ctl.busy)
    `AST_CHK(a_clear_blocks_input, ctl.busy |-> o_in_stall)
    `AST_CHK(a_new_flow_count_one, o_out_valid && (o_out_data.status == ST_NEW ||
        o_out_data.status == ST_NEW_EVICT) |-> o_out_data.packet_count == 64'd1)

endmodule

@@ hw/rtl/fpc_ram.sv @@
// ----------------------------------------------------------------------------
// fpc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/fpc_parser.sv @@
// ----------------------------------------------------------------------------
// fpc_parser
// Byte-wise header capture; issues one table request per frame end or read.
// ----------------------------------------------------------------------------
module fpc_parser import fpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  logic i_adv,
    input  t_in  i_in,
    output t_req o_req
);

    logic [6:0]  r_off;
    logic [15:0] r_eth;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [63:0] r_addrs;
    logic [15:0] r_port;
    t_req        r_req;

    logic [15:0] n_eth;
    logic [3:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [63:0] n_addrs;
    logic [15:0] n_port;
    t_req        n_req;

    logic [6:0]  pos;
    logic [7:0]  b;
    logic [2:0]  sel;
    logic [6:0]  t_cur;
    logic [7:0]  len;
    logic [7:0]  tt;
    logic        ok;
    logic [15:0] port;
    logic [23:0] pp;
    logic [31:0] h;
    logic [15:0] h16;

    always_comb begin
        pos     = r_off;
        b       = i_in.data_byte;
        n_eth   = r_eth;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_addrs = r_addrs;
        n_port  = r_port;
        sel     = 3'(7'd33 - pos);
        t_cur   = 7'd14 + {1'b0, r_ihl, 2'b00};

        if (pos == 7'd12) n_eth[15:8] = b;
        if (pos == 7'd13) n_eth[7:0] = b;
        if (pos == 7'd14) n_ihl = b[3:0];
        if (pos == 7'd23) n_proto = b;
        if (pos >= 7'd26 && pos <= 7'd33) n_addrs[{sel, 3'b000} +: 8] = b;
        // port position follows the IHL captured earlier in the frame
        if (pos > 7'd14 && pos == t_cur + 7'd2) n_port[15:8] = b;
        if (pos > 7'd14 && pos == t_cur + 7'd3) n_port[7:0] = b;

        len  = {1'b0, pos} + 8'd1;
        tt   = 8'd14 + {2'b00, n_ihl, 2'b00};
        ok   = (len >= 8'd34) && (n_eth == ETHERTYPE_IPV4) && (tt <= len);
        port = 16'd0;
        if (n_proto == PROTO_TCP) begin
            ok   = ok && (len >= tt + 8'd20);
            port = n_port;
        end else if (n_proto == PROTO_UDP) begin
            ok   = ok && (len >= tt + 8'd8);
            port = n_port;
        end
        pp  = {n_proto, port};
        h   = n_addrs[63:32] ^ n_addrs[31:0] ^ {8'h00, pp};
        h16 = h[15:0] ^ h[31:16];

        n_req.addrs = n_addrs;
        n_req.pp    = pp;
        n_req.row   = h16[SET_W-1:0];
        n_req.way   = '0;
        if (i_in.operation) begin
            n_req.kind = K_READ;
            n_req.row  = i_in.entry_index[SLOT_W-1:WAY_W];
            n_req.way  = i_in.entry_index[WAY_W-1:0];
        end else if (i_in.last_byte) begin
            n_req.kind = ok ? K_FLOW : K_DROP;
        end else begin
            n_req.kind = K_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_eth   <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_addrs <= '0;
            r_port  <= '0;
        end else if (i_accept && !i_in.operation) begin
            if (i_in.last_byte) begin
                r_off   <= '0;
                r_eth   <= '0;
                r_ihl   <= '0;
                r_proto <= '0;
                r_addrs <= '0;
                r_port  <= '0;
            end else begin
                if (r_off != OFF_MAX) r_off <= r_off + 7'd1;
                r_eth   <= n_eth;
                r_ihl   <= n_ihl;
                r_proto <= n_proto;
                r_addrs <= n_addrs;
                r_port  <= n_port;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.kind <= K_NONE;
        end else if (i_adv) begin
            r_req.kind <= i_accept ? n_req.kind : K_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_req.addrs <= n_req.addrs;
            r_req.pp    <= n_req.pp;
            r_req.row   <= n_req.row;
            r_req.way   <= n_req.way;
        end
    end

    assign o_req = r_req;

endmodule

@@ hw/rtl/fpc_table.sv @@
// ----------------------------------------------------------------------------
// fpc_table
// Flow table: set read, tag compare, LRU update and write-back, result reg.
// ----------------------------------------------------------------------------
module fpc_table import fpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  logic i_out_stall,
    output t_ctl o_ctl,
    output logic o_out_valid,
    output t_out o_out_data
);

    localparam int ROW_W = $bits(t_row);

    logic             r_clr_busy;
    logic [SET_W-1:0] r_clr_row;
    t_req             r_s2;
    logic             r_fwd_valid;
    logic [SET_W-1:0] r_fwd_row;
    t_row             r_fwd_data;
    logic             r_out_valid;
    t_out             r_out;

    logic             adv;
    logic             we;
    logic [SET_W-1:0] waddr;
    t_row             wdata;
    logic [ROW_W-1:0] rdata;
    t_row             init_row;

    t_row             row;
    t_row             new_row;
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim;
    logic [WAY_W-1:0] use_way;
    logic [WAY_W-1:0] age;
    logic             upd;
    t_way             rd;
    t_out             n_out;

    assign adv = !(r_out_valid && i_out_stall);

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            init_row[w]       = '0;
            init_row[w].rec   = WAY_W'(w);
        end
    end

    fpc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (adv),
        .i_raddr (i_req.row),
        .o_rdata (rdata)
    );

    always_comb begin
        // the previous write went to this row after its read was issued
        row = (r_fwd_valid && r_fwd_row == r_s2.row) ? r_fwd_data : t_row'(rdata);

        hit      = 1'b0;
        hit_way  = '0;
        free     = 1'b0;
        free_way = '0;
        victim   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (row[w].valid) begin
                if (!hit && row[w].addrs == r_s2.addrs && row[w].pp == r_s2.pp) begin
                    hit     = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (row[w].rec == WAY_W'(WAYS - 1)) victim = WAY_W'(w);
            end else if (!free) begin
                free     = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        use_way = hit ? hit_way : (free ? free_way : victim);
        age     = row[use_way].rec;

        new_row = row;
        for (int w = 0; w < WAYS; w++) begin
            if (row[w].rec < age) new_row[w].rec = row[w].rec + 1'b1;
        end
        new_row[use_way].rec = '0;
        if (hit) begin
            new_row[use_way].cnt = row[use_way].cnt + 64'd1;
        end else begin
            new_row[use_way].valid = 1'b1;
            new_row[use_way].addrs = r_s2.addrs;
            new_row[use_way].pp    = r_s2.pp;
            new_row[use_way].cnt   = 64'd1;
        end

        upd = adv && (r_s2.kind == K_FLOW);
        rd  = row[r_s2.way];

        n_out = '0;
        case (r_s2.kind)
            K_FLOW: begin
                n_out.status              = hit ? ST_HIT : (free ? ST_NEW : ST_NEW_EVICT);
                n_out.source_address      = r_s2.addrs[63:32];
                n_out.destination_address = r_s2.addrs[31:0];
                n_out.ip_protocol         = r_s2.pp[23:16];
                n_out.destination_port    = r_s2.pp[15:0];
                n_out.packet_count        = new_row[use_way].cnt;
                n_out.slot                = {r_s2.row, use_way};
            end
            K_READ: begin
                n_out.slot = {r_s2.row, r_s2.way};
                if (rd.valid) begin
                    n_out.status              = ST_READ_VALID;
                    n_out.source_address      = rd.addrs[63:32];
                    n_out.destination_address = rd.addrs[31:0];
                    n_out.ip_protocol         = rd.pp[23:16];
                    n_out.destination_port    = rd.pp[15:0];
                    n_out.packet_count        = rd.cnt;
                end else begin
                    n_out.status = ST_READ_EMPTY;
                end
            end
            default: begin
                n_out.status = ST_NOT_COUNTED;
            end
        endcase

        we    = r_clr_busy || upd;
        waddr = r_clr_busy ? r_clr_row : r_s2.row;
        wdata = r_clr_busy ? init_row : new_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_row   <= '0;
            r_s2.kind   <= K_NONE;
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == SET_W'(SETS - 1)) r_clr_busy <= 1'b0;
            end
            if (adv) begin
                r_s2.kind   <= i_req.kind;
                r_fwd_valid <= upd;
                r_out_valid <= (r_s2.kind != K_NONE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2.addrs <= i_req.addrs;
            r_s2.pp    <= i_req.pp;
            r_s2.row   <= i_req.row;
            r_s2.way   <= i_req.way;
            r_fwd_row  <= r_s2.row;
            r_fwd_data <= new_row;
            r_out      <= n_out;
        end
    end

    assign o_ctl.adv   = adv;
    assign o_ctl.busy  = r_clr_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
